### hw/rtl/dfir_pkg.sv
// shared constants, types and coefficient rom of the decimating fir filter
package dfir_pkg;

  localparam int TAPS_DEF        = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS       = 16;
  localparam int ROM_DEPTH       = 32;
  localparam int ROM_IDX_W       = 5;
  localparam int OUT_BITS        = 37;
  localparam int IDX_BITS        = 16;
  localparam int DECIM_W         = 5;
  localparam int PHASE_W         = 4;
  localparam int TAPS_W          = 6;
  localparam int ADDR_BITS       = 3;
  localparam int DATA_BITS       = 32;

  localparam logic [DECIM_W-1:0] MAX_DECIM = 5'd16;
  localparam logic [DECIM_W-1:0] DECIM_RST = 5'd2;
  localparam logic [TAPS_W-1:0]  TAPS_RST  = 6'd32;

  // register index, taken from the word address bit of paddr
  typedef enum logic {
    REG_DECIM = 1'b0,
    REG_TAPS  = 1'b1
  } cfg_reg_t;

  // valid flag and result index that travel alongside the sums
  typedef struct packed {
    logic                valid;
    logic [IDX_BITS-1:0] idx;
  } pipe_tag_t;

  // symmetric low-pass taps in q1.15
  localparam logic signed [COEF_BITS-1:0] COEF_ROM [ROM_DEPTH] = '{
    -16'sd476,  -16'sd509,  16'sd546,   16'sd590,   -16'sd641,  -16'sd702,  16'sd776,   16'sd868,
    -16'sd983,  -16'sd1135, 16'sd1341,  16'sd1639,  -16'sd2107, -16'sd2950, 16'sd4917,  16'sd14751,
    16'sd14751, 16'sd4917,  -16'sd2950, -16'sd2107, 16'sd1639,  16'sd1341,  -16'sd1135, -16'sd983,
    16'sd868,   16'sd776,   -16'sd702,  -16'sd641,  16'sd590,   16'sd546,   -16'sd509,  -16'sd476
  };

  // taps past the end of the rom weigh zero
  function automatic logic signed [COEF_BITS-1:0] coef(input int k);
    logic [31:0] kb;
    kb = 32'(k);
    if (k < ROM_DEPTH) begin
      return COEF_ROM[kb[ROM_IDX_W-1:0]];
    end
    return '0;
  endfunction

endpackage

### hw/rtl/decimating_fir_filter_unit.sv
// top level of the decimating fir filter: config registers, tap cell row and adder tree
//
// Decimating FIR filter. Each accepted input word shifts one signed sample into a row of
// TAPS tap cells (delay line reset to zero), and every decimation_factor-th word, counted
// from the one flagged first, yields the exact 37-bit sum of the leading taps_in_use
// products with the fixed q1.15 low-pass coefficients, together with a 16-bit result
// index that restarts at zero on first. Input words are taken one per clock while the
// output is not stalled with the pipeline full: the tap cells multiply in parallel into
// product registers and the sum goes through a registered adder tree of clog2(TAPS)
// levels. A stalled output only holds back input once the product stage and every tree
// level holds a result; decimated words leave bubbles that absorb output back-pressure.
// A first flag clears the delay line, phase and index before its own sample is taken.
// Registers (APB, 32-bit data): decimation_factor at 0x0 (0 acts as 1, above 16 as 16),
// taps_in_use at 0x4 (0 gives a zero sum); write them only while no result is pending.
module decimating_fir_filter_unit #(
  parameter int TAPS        = dfir_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = dfir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample,
  input  logic                                   in_first,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [dfir_pkg::OUT_BITS-1:0]   out_filtered_value,
  output logic [dfir_pkg::IDX_BITS-1:0]          out_output_index,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [dfir_pkg::ADDR_BITS-1:0]         paddr,
  input  logic [dfir_pkg::DATA_BITS-1:0]         pwdata,
  output logic [dfir_pkg::DATA_BITS-1:0]         prdata,
  output logic                                   pready
);
  import dfir_pkg::*;

  localparam int LVLS   = $clog2(TAPS);
  localparam int LEAVES = 1 << LVLS;
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int SUM_W  = PROD_W + LVLS;
  localparam int EXT_W  = (SUM_W > OUT_BITS) ? SUM_W : OUT_BITS;

  // configuration registers
  logic [DECIM_W-1:0] decim_r;
  logic [TAPS_W-1:0]  taps_r;
  logic               cfg_wr;
  cfg_reg_t           cfg_sel;

  // decimation phase and result index
  logic [PHASE_W-1:0]  phase_r;
  logic [PHASE_W-1:0]  phase_nxt;
  logic [IDX_BITS-1:0] count_r;
  logic [IDX_BITS-1:0] count_nxt;
  logic [DECIM_W-1:0]  decim_eff;
  logic [PHASE_W-1:0]  phase_cur;
  logic [DECIM_W-1:0]  phase_inc;
  logic [IDX_BITS-1:0] count_cur;
  logic                produce;
  logic                accept;

  // product stage tag, sitting in front of the tree
  pipe_tag_t tag0_r;
  pipe_tag_t tag0_nxt;
  logic      leaf_take;

  // tap row and tree
  logic signed [SAMPLE_BITS-1:0] tap_x  [TAPS];
  logic signed [PROD_W-1:0]      tap_p  [TAPS];
  logic [TAPS-1:0]               use_tap;
  logic signed [SUM_W-1:0]       leaf   [LEAVES];
  pipe_tag_t                     root_tag;
  logic signed [SUM_W-1:0]       root_sum;
  logic signed [EXT_W-1:0]       sum_ext;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[ADDR_BITS-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_r <= DECIM_RST;
      taps_r  <= TAPS_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_DECIM: decim_r <= pwdata[DECIM_W-1:0];
        REG_TAPS:  taps_r  <= pwdata[TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_DECIM: prdata = DATA_BITS'(decim_r);
      REG_TAPS:  prdata = DATA_BITS'(taps_r);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- decimation control
  assign in_ready = leaf_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // zero behaves as one, anything past sixteen as sixteen
    decim_eff = decim_r;
    if (decim_r == '0) begin
      decim_eff = DECIM_W'(1);
    end else if (decim_r > MAX_DECIM) begin
      decim_eff = MAX_DECIM;
    end
    phase_cur = in_first ? '0 : phase_r;
    count_cur = in_first ? '0 : count_r;
    produce   = (phase_cur == '0);
    phase_inc = {1'b0, phase_cur} + DECIM_W'(1);
    phase_nxt = (phase_inc >= decim_eff) ? '0 : phase_inc[PHASE_W-1:0];
    count_nxt = produce ? count_cur + IDX_BITS'(1) : count_cur;
    // the product stage loads whenever the tree can take it; only kept words are valid
    tag0_nxt       = tag0_r;
    if (leaf_take) begin
      tag0_nxt.valid = accept && produce;
      tag0_nxt.idx   = count_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      count_r <= '0;
      tag0_r  <= '0;
    end else begin
      tag0_r <= tag0_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- tap cell row
  genvar k;
  generate
    for (k = 0; k < TAPS; k++) begin : g_tap
      assign use_tap[k] = (TAPS_W+1)'(k) < {1'b0, taps_r};

      if (k == 0) begin : g_head
        // the newest sample always enters, first only clears the older stages
        dfir_tap_cell #(
          .SAMPLE_BITS (SAMPLE_BITS),
          .COEF        (coef(k))
        ) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (accept),
          .clr      (1'b0),
          .use_tap  (use_tap[k]),
          .x_in     (in_sample),
          .x_out    (tap_x[k]),
          .prod_out (tap_p[k])
        );
      end else begin : g_body
        dfir_tap_cell #(
          .SAMPLE_BITS (SAMPLE_BITS),
          .COEF        (coef(k))
        ) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (accept),
          .clr      (in_first),
          .use_tap  (use_tap[k]),
          .x_in     (tap_x[k-1]),
          .x_out    (tap_x[k]),
          .prod_out (tap_p[k])
        );
      end
    end

    // pad the tree to a power of two with zero leaves
    for (k = 0; k < LEAVES; k++) begin : g_leaf
      if (k < TAPS) begin : g_used
        assign leaf[k] = SUM_W'(tap_p[k]);
      end else begin : g_pad
        assign leaf[k] = '0;
      end
    end
  endgenerate

  // ---------------------------------------------------------------- adder tree
  dfir_add_tree #(
    .LEAVES (LEAVES),
    .SUM_W  (SUM_W)
  ) u_tree (
    .clk        (clk),
    .rst_n      (rst_n),
    .leaf_tag   (tag0_r),
    .leaf       (leaf),
    .leaf_take  (leaf_take),
    .root_tag   (root_tag),
    .root_ready (out_ready),
    .root_sum   (root_sum)
  );

  // root level doubles as the output register
  assign sum_ext            = EXT_W'(root_sum);
  assign out_valid          = root_tag.valid;
  assign out_output_index   = root_tag.idx;
  assign out_filtered_value = sum_ext[OUT_BITS-1:0];

endmodule

### hw/rtl/dfir_tap_cell.sv
// one tap cell: a delay line stage, its coefficient multiplier and product register
module dfir_tap_cell #(
  parameter int SAMPLE_BITS = dfir_pkg::SAMPLE_BITS_DEF,
  parameter logic signed [dfir_pkg::COEF_BITS-1:0] COEF = '0
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                shift_en,
  input  logic                                                clr,
  input  logic                                                use_tap,
  input  logic signed [SAMPLE_BITS-1:0]                       x_in,
  output logic signed [SAMPLE_BITS-1:0]                       x_out,
  output logic signed [SAMPLE_BITS+dfir_pkg::COEF_BITS-1:0]   prod_out
);
  import dfir_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] x_nxt;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [PROD_W-1:0]      x_ext;
  logic signed [PROD_W-1:0]      c_ext;

  always_comb begin
    x_nxt    = clr ? '0 : x_in;
    x_ext    = PROD_W'(x_nxt);
    c_ext    = PROD_W'(COEF);
    prod_nxt = use_tap ? x_ext * c_ext : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
    end else if (shift_en) begin
      x_r <= x_nxt;
    end
  end

  // product follows the window of the word just taken
  always_ff @(posedge clk) begin
    if (shift_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign x_out    = x_r;
  assign prod_out = prod_r;

endmodule

### hw/rtl/dfir_add_tree.sv
// registered binary adder tree with per-level valid and stall collapsing
module dfir_add_tree #(
  parameter int LEAVES = 32,
  parameter int SUM_W  = 37
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dfir_pkg::pipe_tag_t      leaf_tag,
  input  logic signed [SUM_W-1:0]  leaf [LEAVES],
  output logic                     leaf_take,
  output dfir_pkg::pipe_tag_t      root_tag,
  input  logic                     root_ready,
  output logic signed [SUM_W-1:0]  root_sum
);
  import dfir_pkg::*;

  localparam int LVLS = $clog2(LEAVES);

  // heap layout: node 1 is the root, children of i are 2i and 2i+1
  logic signed [SUM_W-1:0] node_w [1:2*LEAVES-1];
  logic signed [SUM_W-1:0] node_r [1:LEAVES-1];
  pipe_tag_t               tag_r  [LVLS];
  pipe_tag_t               tag_in [LVLS];
  logic [LVLS-1:0]         lvl_en;

  // a level may load when empty or when its contents move on
  always_comb begin
    lvl_en[0] = !tag_r[0].valid || root_ready;
    for (int d = 1; d < LVLS; d++) begin
      lvl_en[d] = !tag_r[d].valid || lvl_en[d-1];
    end
  end

  assign leaf_take = !leaf_tag.valid || lvl_en[LVLS-1];

  genvar i, d, j;
  generate
    for (i = 1; i < LEAVES; i++) begin : g_node_w
      assign node_w[i] = node_r[i];
    end
    for (i = 0; i < LEAVES; i++) begin : g_leaf_w
      assign node_w[LEAVES+i] = leaf[i];
    end

    for (d = 0; d < LVLS; d++) begin : g_lvl
      if (d == LVLS-1) begin : g_in_leaf
        assign tag_in[d] = leaf_tag;
      end else begin : g_in_node
        assign tag_in[d] = tag_r[d+1];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tag_r[d] <= '0;
        end else if (lvl_en[d]) begin
          tag_r[d] <= tag_in[d];
        end
      end

      for (j = 0; j < (1 << d); j++) begin : g_add
        always_ff @(posedge clk) begin
          if (lvl_en[d]) begin
            node_r[(1 << d) + j] <= node_w[2*((1 << d) + j)] + node_w[2*((1 << d) + j) + 1];
          end
        end
      end
    end
  endgenerate

  assign root_tag = tag_r[0];
  assign root_sum = node_r[1];

endmodule

### hw/rtl/dfir_checker.sv
// port-level checks of the decimating fir filter and their binding
module dfir_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [dfir_pkg::OUT_BITS-1:0] out_filtered_value,
  input logic [dfir_pkg::IDX_BITS-1:0]        out_output_index,
  input logic                                 pready
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word pending right after reset");

  // with nothing waiting at the output every tree level can move, so input is taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held back while no result waits");

  // a waiting result word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_value)
      && $stable(out_output_index))
    else $error("result word changed while stalled");

  // register writes never wait
  a_no_wait: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("config port inserted a wait state");

endmodule

bind decimating_fir_filter_unit dfir_checker u_dfir_checker (.*);

### test/testbench.sv
// self-checking testbench for the decimating fir filter unit
//
// Each word is sent on the input channel and a model of the filter in this file predicts the
// result it causes, if any. The model holds its own delay line, decimation phase and result
// counter. Results from the block are compared field by field with the oldest prediction.
// The run goes through the reset settings, the corner settings of both registers, a
// full-scale sum, and random streams under four idling patterns.
module testbench;
  import dfir_pkg::*;

  // idling pattern of the two channels
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // one predicted result word
  typedef struct packed {
    logic signed [OUT_BITS-1:0] value;
    logic [IDX_BITS-1:0]        index;
  } fir_result_t;

  localparam int NUM_TAPS      = 32;
  localparam int SETTLE_CYCLES = 12;    // more than the adder tree latency
  localparam int STALL_LIMIT   = 5000;  // cycles with no word moving on either side
  localparam int MAX_GAP       = 30;
  localparam int MAX_PRINTED   = 30;

  // low-pass taps in q1.15, symmetric about the middle
  localparam int TAP_WEIGHTS [NUM_TAPS] = '{
    -476, -509, 546, 590, -641, -702, 776, 868,
    -983, -1135, 1341, 1639, -2107, -2950, 4917, 14751,
    14751, 4917, -2950, -2107, 1639, 1341, -1135, -983,
    868, 776, -702, -641, 590, 546, -509, -476
  };

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [15:0]          in_sample;
  logic                        in_first;
  logic                        out_valid;
  logic                        out_ready = 1'b1;
  logic signed [OUT_BITS-1:0]  out_filtered_value;
  logic [IDX_BITS-1:0]         out_output_index;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ADDR_BITS-1:0]        paddr;
  logic [DATA_BITS-1:0]        pwdata;
  logic [DATA_BITS-1:0]        prdata;
  logic                        pready;

  // model state of the filter
  int                  delay_line [NUM_TAPS];
  int unsigned         decim_phase;
  logic [IDX_BITS-1:0] result_count;
  logic [4:0]          decim_reg;
  logic [5:0]          taps_reg;

  fir_result_t pending_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          mismatches;
  int          words_sent;
  int          results_checked;
  int          settings_used;
  int          quiet_cycles = 0;

  decimating_fir_filter_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .in_first           (in_first),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .out_output_index   (out_output_index),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one line per mismatch, printing stops after a while but the count goes on
  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  // filter model: shift the sample in, form the sum, keep one result out of decim
  task automatic predict_filter(input logic signed [15:0] sample, input logic first);
    longint      acc;
    int unsigned used_taps;
    int unsigned decim;
    fir_result_t res;
    if (first) begin
      foreach (delay_line[k]) delay_line[k] = 0;
      decim_phase  = 0;
      result_count = '0;
    end
    for (int k = NUM_TAPS - 1; k > 0; k--) begin
      delay_line[k] = delay_line[k-1];
    end
    delay_line[0] = int'(sample);
    used_taps = (taps_reg > NUM_TAPS) ? NUM_TAPS : taps_reg;
    acc = 0;
    for (int k = 0; k < used_taps; k++) begin
      acc += longint'(TAP_WEIGHTS[k]) * longint'(delay_line[k]);
    end
    // zero acts as one, anything above sixteen as sixteen
    decim = (decim_reg == 0) ? 1 : ((decim_reg > 16) ? 16 : decim_reg);
    if (decim_phase == 0) begin
      res.value = acc[OUT_BITS-1:0];
      res.index = result_count;
      pending_results.push_back(res);
      result_count = result_count + 1'b1;
    end
    decim_phase++;
    if (decim_phase >= decim) begin
      decim_phase = 0;
    end
  endtask

  // send one word; the valid line only drops when a gap is wanted
  task automatic send_word(input logic signed [15:0] sample, input logic first);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= sample;
    in_first  <= first;
    do @(posedge clk); while (!in_ready);
    predict_filter(sample, first);
    words_sent++;
  endtask

  // stop sending, let every predicted result come out, then let the pipeline settle
  task automatic drain_filter();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write, setup then access; pready is always high
  task automatic write_reg(input cfg_reg_t reg_sel, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == REG_DECIM) begin
      decim_reg = value[4:0];
    end else begin
      taps_reg = value[5:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_filter(input logic [31:0] decim, input logic [31:0] taps);
    drain_filter();
    write_reg(REG_DECIM, decim);
    write_reg(REG_TAPS, taps);
    settings_used++;
  endtask

  // mostly full-range noise, with extremes and small values mixed in
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] matched_extreme(input int k, input logic flip);
    if ((TAP_WEIGHTS[k] < 0) ^ flip) begin
      return 16'sh8000;
    end
    return 16'sh7fff;
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    fir_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: value %0d index %0d",
                                  out_filtered_value, out_output_index));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_filtered_value !== want.value) begin
          report_mismatch($sformatf("filtered_value %0d, expected %0d (index %0d)",
                                    out_filtered_value, want.value, want.index));
        end
        if (out_output_index !== want.index) begin
          report_mismatch($sformatf("output_index %0d, expected %0d",
                                    out_output_index, want.index));
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset settings, first flag mid-stream, extreme samples
  task automatic test_reset_defaults();
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh0000, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(16'sh5555, 1'b0);
    send_word(16'shaaaa, 1'b0);
    for (int i = 0; i < 14; i++) begin
      send_word(16'sh0000, 1'b0);
    end
    send_word(16'sd100, 1'b1);
    send_word(-16'sd100, 1'b0);
    send_word(16'sh8000, 1'b0);
  endtask

  // decimation zero and above sixteen, taps zero and above the rom
  task automatic test_register_corners();
    set_filter(0, 0);
    for (int i = 0; i < 6; i++) send_word(pick_sample(), i == 0);
    set_filter(31, 63);
    for (int i = 0; i < 40; i++) send_word(pick_sample(), i == 0);
    set_filter(17, 33);
    for (int i = 0; i < 20; i++) send_word(pick_sample(), 1'b0);
    set_filter(16, 1);
    for (int i = 0; i < 20; i++) send_word(pick_sample(), 1'b0);
    set_filter(1, 32);
    for (int i = 0; i < 8; i++) send_word(pick_sample(), i == 0);
  endtask

  // largest positive and negative sums, then the zero-fed tail
  task automatic test_full_scale();
    set_filter(1, 32);
    for (int k = NUM_TAPS - 1; k >= 0; k--) begin
      send_word(matched_extreme(k, 1'b0), k == NUM_TAPS - 1);
    end
    for (int k = NUM_TAPS - 1; k >= 0; k--) begin
      send_word(matched_extreme(k, 1'b1), 1'b0);
    end
    for (int i = 0; i < NUM_TAPS - 1; i++) send_word(16'sh0000, 1'b0);
  endtask

  // random streams under every idling pattern and a spread of settings
  task automatic test_random_streams();
    logic [31:0] decim;
    logic [31:0] taps;
    for (int m = 0; m < 4; m++) begin
      case (idle_mode_t'(m))
        IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SENDER:   begin send_idle_pct = 69; recv_stall_pct = 0;  end
        IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default:       begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      endcase
      for (int s = 0; s < 4; s++) begin
        case (s)
          0: begin decim = 1;  taps = 32; end
          1: begin decim = 16; taps = 1;  end
          default: begin
            decim = $urandom_range(31);
            taps  = $urandom_range(63);
            // upper pwdata bits are don't-care for the register
            if ($urandom_range(3) == 0) begin
              decim[31:5] = 27'($urandom);
              taps[31:6]  = 26'($urandom);
            end
          end
        endcase
        set_filter(decim, taps);
        for (int i = 0; i < 96; i++) begin
          send_word(pick_sample(), (i == 0 && s != 3) || $urandom_range(49) == 0);
        end
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample      = '0;
    in_first       = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    words_sent     = 0;
    results_checked = 0;
    settings_used  = 1;
    decim_reg      = 5'd2;
    taps_reg       = 6'd32;
    decim_phase    = 0;
    result_count   = '0;
    foreach (delay_line[k]) delay_line[k] = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_corners();
    test_full_scale();
    test_random_streams();

    drain_filter();
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("%0d input words sent, %0d result words checked, %0d register settings",
             words_sent, results_checked, settings_used);
    $display("covered reset defaults, register corners, full-scale sums, idling patterns");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
